// ----- rtl/core/bvie_pkg.sv -----
// shared constants, codes and control types for the bit vector insert/erase unit
// no dependencies
`timescale 1ns / 1ps

package bvie_pkg;

  localparam int CAPACITY_DEF = 256;

  // field widths
  localparam int CMD_W = 3;
  localparam int IDX_W = 9;
  localparam int LEN_W = 9;
  localparam int ERR_W = 2;

  // stream payload widths (rounded up to whole bytes)
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_START_LENGTH = 1'b0;

  // command codes
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_SET    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ERASE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd4;

  // error codes
  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    ST_EMPTY = 2'b01,
    ST_HOLD  = 2'b10
  } bvie_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic exec;  // execute the accepted command
    logic load;  // start_length write: clear store, load length
  } bvie_cmd_t;

endpackage

// ----- rtl/core/bit_vector_insert_erase_unit.sv -----
// top level of the bit vector insert/erase unit
// depends on bvie_pkg, bvie_ctrl, bvie_dpath
`timescale 1ns / 1ps

// usage
//   in_*   : one command per transaction. in_tuser carries the command code,
//            in_tdata carries index and bit_value.
//   out_*  : one result per command: read_bit, length after the command, error.
//   cfg_*  : register start_length at byte addresses 0 to 3 (paddr[2] low). writing
//            it clears the whole store and loads the length (saturated at
//            CAPACITY). only write while no result is pending.
//   result: valid in the cycle after the command is accepted.
//   throughput: one command per cycle while results are taken. insert and
//            erase are a masked parallel shift across the full flip-flop bit
//            store, so every command completes as it is accepted.
//   stall: the result register holds until out_tready; while it is full and
//            not being taken, in_tready is low. a new command is accepted in
//            the same cycle the held result leaves.
//   reset: synchronous, active low. store cleared, length and start_length 0,
//            no result pending.
//   errors: out-of-range index or insert into a full vector reports the
//            error code and leaves the store and length unchanged.

module bit_vector_insert_erase_unit #(
  parameter int CAPACITY = bvie_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bvie_pkg::IN_DATA_W-1:0]      in_tdata,   // index[8:0], bit_value[9]
  input  logic [bvie_pkg::CMD_W-1:0]          in_tuser,   // command[2:0]
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bvie_pkg::OUT_DATA_W-1:0]     out_tdata,  // read_bit[0], length[9:1],
                                                          // error[11:10]
  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [bvie_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [bvie_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [bvie_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);
  import bvie_pkg::*;

  bvie_cmd_t         cmd;
  logic              read_bit;
  logic [LEN_W-1:0]  length;
  logic [ERR_W-1:0]  error;

  // no wait states on the register port
  assign cfg_pready = 1'b1;

  // handshakes and register write decode
  bvie_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cmd         (cmd)
  );

  // bit store, length and result register
  bvie_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .command    (in_tuser),
    .index      (in_tdata[IDX_W-1:0]),
    .bit_value  (in_tdata[IDX_W]),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .read_bit   (read_bit),
    .length     (length),
    .error      (error)
  );

  assign out_tdata = {{(OUT_DATA_W - 1 - LEN_W - ERR_W){1'b0}}, error, length, read_bit};

  // a held result that is not taken blocks new commands
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("command accepted while result stalled");

  // every accepted command yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("no result after accepted command");

  // only get returns a nonzero read bit
  a_read_bit_get_only: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != CMD_GET) |=> !out_tdata[0])
    else $error("read bit set for a command other than get");

  // error field carries only defined codes
  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[11:10] == ERR_OK) || (out_tdata[11:10] == ERR_RANGE) ||
                   (out_tdata[11:10] == ERR_FULL))
    else $error("undefined error code");

endmodule

// ----- rtl/core/bvie_ctrl.sv -----
// controller: stream handshakes, result register occupancy, register write decode
// depends on bvie_pkg
`timescale 1ns / 1ps

module bvie_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [bvie_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  output bvie_pkg::bvie_cmd_t                cmd
);
  import bvie_pkg::*;

  bvie_state_t state_r, state_nxt;
  logic        in_fire;

  // result slot is free, or it empties in this cycle
  assign in_tready  = (state_r == ST_EMPTY) || out_tready;
  assign out_tvalid = (state_r == ST_HOLD);
  assign in_fire    = in_tvalid && in_tready;

  assign cmd.exec = in_fire;
  assign cmd.load = cfg_psel && cfg_penable && cfg_pwrite &&
                    (cfg_paddr[CFG_ADDR_W-1] == REG_START_LENGTH);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_EMPTY: begin
        if (in_fire) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_tready && !in_fire) state_nxt = ST_EMPTY;
      end
      default: state_nxt = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/core/bvie_dpath.sv -----
// datapath: bit store with masked parallel shift, length, start_length register,
// result register. depends on bvie_pkg
`timescale 1ns / 1ps

module bvie_dpath #(
  parameter int CAPACITY = bvie_pkg::CAPACITY_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bvie_pkg::bvie_cmd_t              cmd,
  input  logic [bvie_pkg::CMD_W-1:0]       command,
  input  logic [bvie_pkg::IDX_W-1:0]       index,
  input  logic                             bit_value,
  input  logic [bvie_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [bvie_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             read_bit,
  output logic [bvie_pkg::LEN_W-1:0]       length,
  output logic [bvie_pkg::ERR_W-1:0]       error
);
  import bvie_pkg::*;

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = (LW > IDX_W) ? LW : IDX_W;
  localparam logic [CW-1:0] CAP_EXT = CW'(CAPACITY);

  logic [CAPACITY-1:0] store_r, store_nxt;
  logic [LW-1:0]       len_r, len_nxt;
  logic [LEN_W-1:0]    start_r;
  logic                rd_r, rd_nxt;
  logic [LEN_W-1:0]    len_out_r;
  logic [ERR_W-1:0]    err_r, err_nxt;

  logic [CW-1:0]       len_ext, pos_ext, ins_pos, wdata_ext, start_sat;
  logic [IW-1:0]       pos_idx;
  logic [CAPACITY-1:0] ins_vec, ers_vec, set_vec;
  logic                ins_range, ins_full, acc_range;

  assign len_ext   = CW'(len_r);
  assign pos_ext   = CW'(index);
  assign pos_idx   = pos_ext[IW-1:0];
  assign ins_pos   = (command == CMD_PUSH) ? len_ext : pos_ext;
  assign acc_range = (pos_ext >= len_ext);
  assign ins_range = (ins_pos > len_ext);
  assign ins_full  = (len_ext >= CAP_EXT);

  // start length saturates at the capacity
  assign wdata_ext = CW'(cfg_pwdata[LEN_W-1:0]);
  assign start_sat = (wdata_ext > CAP_EXT) ? CAP_EXT : wdata_ext;

  // shifted copies of the store; bits at or above the length are always zero
  always_comb begin
    ins_vec[0] = (ins_pos == '0) ? bit_value : store_r[0];
    for (int i = 1; i < CAPACITY; i++) begin
      if (CW'(i) < ins_pos)       ins_vec[i] = store_r[i];
      else if (CW'(i) == ins_pos) ins_vec[i] = bit_value;
      else                        ins_vec[i] = store_r[i-1];
    end
    for (int i = 0; i < CAPACITY - 1; i++) begin
      ers_vec[i] = (CW'(i) < pos_ext) ? store_r[i] : store_r[i+1];
    end
    ers_vec[CAPACITY-1] = (CW'(CAPACITY - 1) < pos_ext) ? store_r[CAPACITY-1] : 1'b0;
    set_vec = store_r;
    set_vec[pos_idx] = bit_value;
  end

  always_comb begin
    store_nxt = store_r;
    len_nxt   = len_r;
    rd_nxt    = 1'b0;
    err_nxt   = ERR_OK;
    case (command) inside
      CMD_GET: begin
        if (acc_range) err_nxt = ERR_RANGE;
        else           rd_nxt  = store_r[pos_idx];
      end
      CMD_SET: begin
        if (acc_range) err_nxt   = ERR_RANGE;
        else           store_nxt = set_vec;
      end
      CMD_INSERT, CMD_PUSH: begin
        if (ins_range) begin
          err_nxt = ERR_RANGE;
        end else if (ins_full) begin
          err_nxt = ERR_FULL;
        end else begin
          store_nxt = ins_vec;
          len_nxt   = len_r + LW'(1);
        end
      end
      CMD_ERASE: begin
        if (acc_range) begin
          err_nxt = ERR_RANGE;
        end else begin
          store_nxt = ers_vec;
          len_nxt   = len_r - LW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      len_r   <= '0;
      start_r <= '0;
    end else if (cmd.load) begin
      store_r <= '0;
      len_r   <= start_sat[LW-1:0];
      start_r <= start_sat[LEN_W-1:0];
    end else if (cmd.exec) begin
      store_r <= store_nxt;
      len_r   <= len_nxt;
    end
  end

  // result payload; the reported length wraps at the field width
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_r      <= rd_nxt;
      len_out_r <= LEN_W'(len_nxt);
      err_r     <= err_nxt;
    end
  end

  assign cfg_prdata = CFG_DATA_W'(start_r);
  assign read_bit   = rd_r;
  assign length     = len_out_r;
  assign error      = err_r;

endmodule
